/* hw/rtl/ppa_pkg.sv */
package ppa_pkg;

   // field widths
   localparam int COORD_W   = 20;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int CROSS_T_W = 2 * COORD_W + 1;
   localparam int CROSS_W   = 51;
   localparam int LEN_W     = 31;
   localparam int AREA_W    = 48;
   localparam int CNT_OUT_W = 11;
   localparam int SQ_W      = 42;
   localparam int ROOT_W    = SQ_W / 2;
   localparam int REM_W     = ROOT_W + 3;

   // square root takes one result bit per step
   localparam int SQRT_STEPS = ROOT_W;
   localparam int STEP_W     = $clog2(SQRT_STEPS);

   // multiplier phases
   localparam logic [2:0] PH_DXDX  = 3'd0;
   localparam logic [2:0] PH_DYDY  = 3'd1;
   localparam logic [2:0] PH_XAYB  = 3'd2;
   localparam logic [2:0] PH_XBYA  = 3'd3;
   localparam logic [2:0] PH_DRAIN = 3'd4;

   localparam logic [LEN_W-1:0]     LEN_MAX       = {LEN_W{1'b1}};
   localparam logic [AREA_W-1:0]    AREA_MAX      = {AREA_W{1'b1}};
   localparam logic [CNT_OUT_W-1:0] COUNT_OUT_MAX = {CNT_OUT_W{1'b1}};
   localparam logic signed [CROSS_W:0] CROSS_HI = {2'b00, {(CROSS_W-1){1'b1}}};
   localparam logic signed [CROSS_W:0] CROSS_LO = {2'b11, {(CROSS_W-1){1'b0}}};

   typedef struct packed {
      logic       capture;
      logic       first_load;
      logic       set_dropped;
      logic       mul_en;
      logic [2:0] mul_phase;
      logic       edge_close;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       accumulate;
      logic       emit;
      logic       clear;
   } ppa_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_below_max;
      logic count_above_one;
      logic last;
   } ppa_status_type;

endpackage

/* hw/rtl/ppa_ctrl.sv */
module ppa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  ppa_pkg::ppa_status_type status,
   output ppa_pkg::ppa_cmd_type    cmd
);
   import ppa_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_SQRT   = 3'd3;
   localparam logic [2:0] S_ACC    = 3'd4;
   localparam logic [2:0] S_CLOSE  = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        phase_ff, phase_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              closing_ff, closing_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= PH_DXDX;
         step_ff    <= '0;
         closing_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         step_ff    <= step_in;
         closing_ff <= closing_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      step_in    = step_ff;
      closing_in = closing_ff;
      cmd        = '0;
      cmd.mul_phase  = phase_ff;
      cmd.edge_close = closing_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (status.count_zero) begin
               cmd.first_load = 1'b1;
               state_in       = S_CLOSE;
            end else if (status.count_below_max) begin
               closing_in = 1'b0;
               phase_in   = PH_DXDX;
               state_in   = S_MUL;
            end else begin
               cmd.set_dropped = 1'b1;
               state_in        = S_CLOSE;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            if (phase_ff == PH_DRAIN) begin
               cmd.sqrt_init = 1'b1;
               step_in       = '0;
               state_in      = S_SQRT;
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = S_ACC;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_ACC: begin
            cmd.accumulate = 1'b1;
            state_in       = closing_ff ? S_EMIT : S_CLOSE;
         end
         S_CLOSE: begin
            priority if (!status.last) begin
               state_in = S_IDLE;
            end else if (status.count_above_one) begin
               closing_in = 1'b1;
               phase_in   = PH_DXDX;
               state_in   = S_MUL;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.emit   = 1'b1;
            cmd.clear  = 1'b1;
            closing_in = 1'b0;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/ppa_datapath.sv */
module ppa_datapath #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ppa_pkg::ppa_cmd_type                  cmd,
   output ppa_pkg::ppa_status_type               status,
   input  logic signed [ppa_pkg::COORD_W-1:0]    req_x_coord,
   input  logic signed [ppa_pkg::COORD_W-1:0]    req_y_coord,
   input  logic                                  req_last_vertex,
   output logic [ppa_pkg::LEN_W-1:0]             rsp_perimeter,
   output logic [ppa_pkg::AREA_W-1:0]            rsp_area,
   output logic [ppa_pkg::CNT_OUT_W-1:0]         rsp_vertex_count,
   output logic                                  rsp_overflow
);
   import ppa_pkg::*;

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   logic signed [COORD_W-1:0]   cur_x_ff, cur_y_ff, first_x_ff, first_y_ff;
   logic signed [COORD_W-1:0]   prev_x_ff, prev_y_ff;
   logic                        last_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [LEN_W-1:0]            len_sum_ff;
   logic signed [CROSS_W-1:0]   cross_sum_ff;
   logic                        dropped_ff;

   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic [SQ_W-1:0]             sq_ff;
   logic signed [CROSS_T_W-1:0] cr_ff;
   logic [SQ_W-1:0]             sqn_ff;
   logic [REM_W-1:0]            rem_ff;
   logic [ROOT_W-1:0]           root_ff;

   // edge operands: from previous vertex to current or back to first
   logic signed [DIFF_W-1:0] ax, ay, bx, by, dx, dy, ma, mb;

   always_comb begin
      ax = {prev_x_ff[COORD_W-1], prev_x_ff};
      ay = {prev_y_ff[COORD_W-1], prev_y_ff};
      bx = cmd.edge_close ? {first_x_ff[COORD_W-1], first_x_ff}
                          : {cur_x_ff[COORD_W-1], cur_x_ff};
      by = cmd.edge_close ? {first_y_ff[COORD_W-1], first_y_ff}
                          : {cur_y_ff[COORD_W-1], cur_y_ff};
      dx = bx - ax;
      dy = by - ay;
      unique case (cmd.mul_phase)
         PH_DXDX: begin ma = dx; mb = dx; end
         PH_DYDY: begin ma = dy; mb = dy; end
         PH_XAYB: begin ma = ax; mb = by; end
         PH_XBYA: begin ma = bx; mb = ay; end
         default: begin ma = '0; mb = '0; end
      endcase
      prod_in = ma * mb;
   end

   // one result bit per step
   logic [REM_W-1:0] rem_sh, trial;
   logic             fits;

   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], sqn_ff[SQ_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      fits   = (rem_sh >= trial);
   end

   // saturating accumulation
   logic [LEN_W:0]            len_add;
   logic signed [CROSS_W:0]   cross_add;
   logic [LEN_W-1:0]          len_next;
   logic signed [CROSS_W-1:0] cross_next;

   always_comb begin
      len_add   = {1'b0, len_sum_ff} + (LEN_W+1)'(root_ff);
      len_next  = len_add[LEN_W] ? LEN_MAX : len_add[LEN_W-1:0];
      cross_add = $signed({cross_sum_ff[CROSS_W-1], cross_sum_ff})
                + $signed({{(CROSS_W+1-CROSS_T_W){cr_ff[CROSS_T_W-1]}}, cr_ff});
      priority if (cross_add > CROSS_HI) begin
         cross_next = CROSS_HI[CROSS_W-1:0];
      end else if (cross_add < CROSS_LO) begin
         cross_next = CROSS_LO[CROSS_W-1:0];
      end else begin
         cross_next = cross_add[CROSS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         count_ff     <= '0;
         len_sum_ff   <= '0;
         cross_sum_ff <= '0;
         dropped_ff   <= 1'b0;
      end else if (cmd.clear) begin
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         count_ff     <= '0;
         len_sum_ff   <= '0;
         cross_sum_ff <= '0;
         dropped_ff   <= 1'b0;
      end else begin
         if (cmd.first_load) begin
            first_x_ff <= cur_x_ff;
            first_y_ff <= cur_y_ff;
            prev_x_ff  <= cur_x_ff;
            prev_y_ff  <= cur_y_ff;
            count_ff   <= CNT_W'(1);
         end
         if (cmd.set_dropped) begin
            dropped_ff <= 1'b1;
         end
         if (cmd.accumulate) begin
            len_sum_ff   <= len_next;
            cross_sum_ff <= cross_next;
            if (!cmd.edge_close) begin
               prev_x_ff <= cur_x_ff;
               prev_y_ff <= cur_y_ff;
               count_ff  <= count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_x_ff <= req_x_coord;
         cur_y_ff <= req_y_coord;
         last_ff  <= req_last_vertex;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
         unique case (cmd.mul_phase)
            PH_DYDY:  sq_ff <= prod_ff[SQ_W-1:0];
            PH_XAYB:  sq_ff <= sq_ff + prod_ff[SQ_W-1:0];
            PH_XBYA:  cr_ff <= prod_ff[CROSS_T_W-1:0];
            PH_DRAIN: cr_ff <= cr_ff - prod_ff[CROSS_T_W-1:0];
            default: ;
         endcase
      end
      if (cmd.sqrt_init) begin
         sqn_ff  <= sq_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         sqn_ff  <= {sqn_ff[SQ_W-3:0], 2'b00};
         rem_ff  <= fits ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], fits};
      end
   end

   assign status.count_zero      = (count_ff == '0);
   assign status.count_below_max = (32'(count_ff) < 32'(MAX_VERTICES));
   assign status.count_above_one = (32'(count_ff) > 32'd1);
   assign status.last            = last_ff;

   // result fields, read while the emit strobe is up
   logic [CROSS_W-1:0] mag;
   logic [CROSS_W-2:0] half;

   always_comb begin
      mag  = cross_sum_ff[CROSS_W-1] ? (CROSS_W)'(-cross_sum_ff) : cross_sum_ff;
      half = mag[CROSS_W-1:1];
      rsp_area = (half[CROSS_W-2:AREA_W] != '0) ? AREA_MAX : half[AREA_W-1:0];
      rsp_perimeter    = len_sum_ff;
      rsp_vertex_count = (32'(count_ff) > 32'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX
                                                              : CNT_OUT_W'(count_ff);
      rsp_overflow     = dropped_ff;
   end

endmodule

/* hw/rtl/polygon_perimeter_and_area.sv */
// channel   ports                                           handshake
// -------   ---------------------------------------------   --------------------------
// request   req_x_coord, req_y_coord, req_last_vertex       start high, busy low
// response  rsp_perimeter, rsp_area, rsp_vertex_count,      rsp_valid, one cycle,
//           rsp_overflow                                    cannot be held off
//
// an item that is the first vertex or a dropped one passes accept, decode and close check;
// an item that adds an edge also takes the shared 21x21 multiplier (phases dx*dx, dy*dy,
// xa*yb, xb*ya and drain), 21 square root steps at one result bit each and an accumulate
// step between decode and close check
// the item marked last adds a closing edge (if count > 1) and 1 cycle of rsp_valid
// synchronous active-high reset clears the polygon state and returns the fsm to idle
// results go out on a single-cycle strobe; the receiver cannot stall the block
module polygon_perimeter_and_area #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [ppa_pkg::COORD_W-1:0] req_x_coord,
   input  logic signed [ppa_pkg::COORD_W-1:0] req_y_coord,
   input  logic                               req_last_vertex,
   output logic                               rsp_valid,
   output logic [ppa_pkg::LEN_W-1:0]          rsp_perimeter,
   output logic [ppa_pkg::AREA_W-1:0]         rsp_area,
   output logic [ppa_pkg::CNT_OUT_W-1:0]      rsp_vertex_count,
   output logic                               rsp_overflow
);
   import ppa_pkg::*;

   // command and status between sequencer and datapath
   ppa_cmd_type    cmd;
   ppa_status_type status;

   // sequencer: vertex decode, multiplier phases, square root steps, closing edge
   ppa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // datapath: vertex registers, shared multiplier, root unit, saturating sums
   ppa_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_last_vertex  (req_last_vertex),
      .rsp_perimeter    (rsp_perimeter),
      .rsp_area         (rsp_area),
      .rsp_vertex_count (rsp_vertex_count),
      .rsp_overflow     (rsp_overflow)
   );

   // strobe is high for the single emit cycle, just before state clears
   assign rsp_valid = cmd.emit;

endmodule
